FILE: rtl/searchable_stack_engine_core_defines.svh
// Assertion macros shared by the searchable stack engine RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SEARCHABLE_STACK_ENGINE_CORE_DEFINES_SVH
`define SEARCHABLE_STACK_ENGINE_CORE_DEFINES_SVH

`define SSE_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define SSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sse_pkg.sv
// Package for the searchable stack engine: sizes, codes and request/result types.
// No dependencies; every RTL file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  localparam int ENTRIES_W = 5;

  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_SEARCH = 3'd2,
    MODE_MODIFY = 3'd3,
    MODE_DELETE = 3'd4,
    MODE_MAXMIN = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_MINMAX
  } state_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] replacement;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] result_value;
    logic signed [DATA_W-1:0] minimum_value;
    logic [POS_W-1:0]         position;
    logic [ENTRIES_W-1:0]     entries_held;
  } rsp_t;

  typedef struct packed {
    logic eq;
    logic above_max;
    logic below_min;
  } cmp_t;

endpackage

`default_nettype wire

FILE: rtl/searchable_stack_engine_core.sv
// Searchable stack engine top level: sequencer, fill count and result register.
// Uses sse_pkg, sse_ram, sse_cmp and the assertion macros in the defines header.
// A request is taken in S_IDLE and decoded in S_DECODE; push, unused modes and an empty
// stack answer from there. Pop reads the top in S_POP; search and modify compare entries from
// the top down in S_SCAN; max/min walks all entries in S_MINMAX; delete scans in S_SCAN and
// then moves each entry above the match down one place in S_SHIFT.
// One storage read per cycle sets the pace; busy drops in the strobe cycle, where a new request
// may start. The receiver cannot stall. Synchronous reset empties the stack.
`timescale 1ns / 1ps
`default_nettype none

module searchable_stack_engine_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire sse_pkg::req_t in_req,
  output logic               out_valid,
  output sse_pkg::rsp_t      out_rsp
);
  import sse_pkg::*;

  `include "searchable_stack_engine_core_defines.svh"

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  req_t               req_r, req_nxt;
  rsp_t               rsp_r, rsp_nxt;
  logic               valid_r, valid_nxt;

  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic signed [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]         raddr;
  logic signed [DATA_W-1:0] rd_data;
  cmp_t                     cmp;
  logic [IDX_W-1:0]         top_idx;
  logic [CNT_W-1:0]         pos_full;

  sse_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  sse_cmp u_cmp (
    .elem    (rd_data),
    .key     (req_r.value),
    .cur_max (rsp_r.result_value),
    .cur_min (rsp_r.minimum_value),
    .res     (cmp)
  );

  assign top_idx  = IDX_W'(cnt_r - CNT_W'(1));
  assign pos_full = cnt_r - CNT_W'(1) - CNT_W'(ptr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    req_nxt   = req_r;
    rsp_nxt   = rsp_r;
    valid_nxt = 1'b0;
    we        = 1'b0;
    waddr     = ptr_r;
    wdata     = rd_data;
    raddr     = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        rsp_nxt.status        = ST_OK;
        rsp_nxt.result_value  = '0;
        rsp_nxt.minimum_value = '0;
        rsp_nxt.position      = '0;
        if (req_r.mode == MODE_PUSH) begin
          if (cnt_r == CNT_W'(DEPTH)) begin
            rsp_nxt.status = ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = cnt_r[IDX_W-1:0];
            wdata   = req_r.value;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (req_r.mode inside {MODE_POP, MODE_SEARCH, MODE_MODIFY,
                                        MODE_DELETE, MODE_MAXMIN}) begin
          if (cnt_r == '0) begin
            rsp_nxt.status = ST_EMPTY;
            valid_nxt      = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            raddr   = top_idx;
            ptr_nxt = top_idx;
            if (req_r.mode == MODE_POP) begin
              state_nxt = S_POP;
            end else if (req_r.mode == MODE_MAXMIN) begin
              rsp_nxt.result_value  = DATA_MIN;
              rsp_nxt.minimum_value = DATA_MAX;
              state_nxt             = S_MINMAX;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end else begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_POP: begin
        rsp_nxt.result_value = rd_data;
        cnt_nxt              = cnt_r - CNT_W'(1);
        valid_nxt            = 1'b1;
        state_nxt            = S_IDLE;
      end

      S_SCAN: begin
        if (cmp.eq) begin
          rsp_nxt.result_value = rd_data;
          rsp_nxt.position     = POS_W'(pos_full);
          if (req_r.mode == MODE_MODIFY) begin
            we        = 1'b1;
            waddr     = ptr_r;
            wdata     = req_r.replacement;
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else if (req_r.mode == MODE_DELETE) begin
            if (CNT_W'(ptr_r) + CNT_W'(1) < cnt_r) begin
              raddr     = ptr_r + IDX_W'(1);
              state_nxt = S_SHIFT;
            end else begin
              cnt_nxt   = cnt_r - CNT_W'(1);
              valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (ptr_r == '0) begin
          rsp_nxt.status = ST_NOTFOUND;
          valid_nxt      = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          ptr_nxt = ptr_r - IDX_W'(1);
          raddr   = ptr_r - IDX_W'(1);
        end
      end

      S_SHIFT: begin
        we      = 1'b1;
        waddr   = ptr_r;
        wdata   = rd_data;
        ptr_nxt = ptr_r + IDX_W'(1);
        if (CNT_W'(ptr_r) + CNT_W'(2) < cnt_r) begin
          raddr = ptr_r + IDX_W'(2);
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_MINMAX: begin
        if (cmp.above_max) begin
          rsp_nxt.result_value = rd_data;
        end
        if (cmp.below_min) begin
          rsp_nxt.minimum_value = rd_data;
        end
        if (ptr_r == '0) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r - IDX_W'(1);
          raddr   = ptr_r - IDX_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rsp_nxt.entries_held = ENTRIES_W'(cnt_nxt);
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

  `SSE_ASSERT_HOLDS(a_cnt_bound, cnt_r <= CNT_W'(DEPTH), "fill count above depth")
  `SSE_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `SSE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but block not busy")
  `SSE_ASSERT_IMPL(a_full_count, out_valid && out_rsp.status == ST_FULL,
                   out_rsp.entries_held == ENTRIES_W'(DEPTH), "full status with stack not full")
  `SSE_ASSERT_IMPL(a_shift_mode, state_r == S_SHIFT, req_r.mode == MODE_DELETE,
                   "entries moved outside a delete")

endmodule

`default_nettype wire

FILE: rtl/sse_ram.sv
// Stack storage: DEPTH words, one write port and one registered read port.
// Depends on sse_pkg for the depth and word width.
`timescale 1ns / 1ps
`default_nettype none

module sse_ram (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [sse_pkg::IDX_W-1:0]        waddr,
  input  wire logic signed [sse_pkg::DATA_W-1:0] wdata,
  input  wire logic [sse_pkg::IDX_W-1:0]        raddr,
  output logic signed [sse_pkg::DATA_W-1:0]     rdata
);
  import sse_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/sse_cmp.sv
// Shared compare unit: tests one stored word for a match and against the running extremes.
// Depends on sse_pkg for the word width and the result type.
`timescale 1ns / 1ps
`default_nettype none

module sse_cmp (
  input  wire logic signed [sse_pkg::DATA_W-1:0] elem,
  input  wire logic signed [sse_pkg::DATA_W-1:0] key,
  input  wire logic signed [sse_pkg::DATA_W-1:0] cur_max,
  input  wire logic signed [sse_pkg::DATA_W-1:0] cur_min,
  output sse_pkg::cmp_t                         res
);
  import sse_pkg::*;

  always_comb begin
    res.eq        = (elem == key);
    res.above_max = (elem > cur_max);
    res.below_min = (elem < cur_min);
  end

endmodule

`default_nettype wire
